// ===== rtl/core/vtp_pkg.sv =====
package vtp_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_COL_X,
    REG_COL_Y,
    REG_COL_Z,
    REG_TRANS_XY,
    REG_TRANS_Z,
    REG_TINT,
    REG_UV,
    REG_MODE
  } reg_idx_t;

  // Output modes; the unused code behaves as full mode.
  typedef enum logic [1:0] {
    MODE_FULL,
    MODE_SHADOW,
    MODE_GI
  } mode_t;

  // Rotated direction component: three Q4.12 x Q2.14 products summed.
  localparam int DIR_W = 33;
  typedef logic signed [DIR_W-1:0] dir_comp_t;

  localparam int SQRT_BITS      = 31;
  localparam int SQRT_PER_STAGE = 4;
  localparam int SQRT_STAGES    = (SQRT_BITS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;
  localparam int DIV_BITS       = 9;
  localparam int DIV_PER_STAGE  = 3;
  localparam int DIV_STAGES     = (DIV_BITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

  // Square stage, sum stage, root stages, divide stages, pack stage.
  localparam int DIR_LAT    = 3 + SQRT_STAGES + DIV_STAGES;
  // Two product and sum stages ahead of the direction unit.
  localparam int PIPE_DEPTH = 2 + DIR_LAT;
  // Position delay line after the scale and reciprocal stages.
  localparam int POS_DLY    = DIR_LAT - 2;

  localparam logic [9:0] FIELD_MID = 10'd511;

  // Reciprocal of 125 for the 65536/1000 rescale: ceil(2^45 / 125).
  localparam logic [38:0] RECIP    = 39'(((64'd1 << 45) / 64'd125) + 64'd1);
  localparam logic [18:0] RECIP_HI = RECIP[38:20];
  localparam logic [19:0] RECIP_LO = RECIP[19:0];

endpackage

// ===== rtl/core/vtp_dir_pack.sv =====
module vtp_dir_pack (
  input  logic                clk,
  input  logic                en,
  input  vtp_pkg::dir_comp_t  comp [3],
  output logic [29:0]         fields
);

  localparam int SS = vtp_pkg::SQRT_STAGES;
  localparam int DS = vtp_pkg::DIV_STAGES;

  logic [31:0] mag_in [3];
  logic [29:0] sh [3];
  logic        big2, big1;

  logic [29:0] d1_mag [3];
  logic        d1_neg [3];
  logic [59:0] d1_sq [3];
  logic [61:0] d2_sum;
  logic [29:0] d2_mag [3];
  logic        d2_neg [3];

  // Halving until every component is below 2^30 is a common shift of 0, 1 or 2.
  always_comb begin
    big2 = 1'b0;
    big1 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = comp[i][vtp_pkg::DIR_W-1] ? 32'(-comp[i]) : 32'(comp[i]);
      big2 = big2 | mag_in[i][31];
      big1 = big1 | mag_in[i][30];
    end
    for (int i = 0; i < 3; i++) begin
      if (big2) begin
        sh[i] = mag_in[i][31:2];
      end else if (big1) begin
        sh[i] = mag_in[i][30:1];
      end else begin
        sh[i] = mag_in[i][29:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_mag[i] <= sh[i];
        d1_neg[i] <= comp[i][vtp_pkg::DIR_W-1];
        d1_sq[i]  <= 60'(sh[i]) * 60'(sh[i]);
      end
      d2_sum <= 62'(d1_sq[0]) + 62'(d1_sq[1]) + 62'(d1_sq[2]);
      d2_mag <= d1_mag;
      d2_neg <= d1_neg;
    end
  end

  // Integer square root, two radicand bits per step.
  logic [61:0] sq_x [SS];
  logic [33:0] sq_rem [SS];
  logic [30:0] sq_root [SS];
  logic [29:0] sq_mag [SS][3];
  logic        sq_neg [SS][3];

  for (genvar s = 0; s < SS; s++) begin : g_sqrt
    logic [61:0] x_src, x_c;
    logic [33:0] rem_src, rem_c;
    logic [30:0] root_src, root_c;
    logic [29:0] mag_src [3];
    logic        neg_src [3];

    if (s == 0) begin : g_first
      assign x_src    = d2_sum;
      assign rem_src  = '0;
      assign root_src = '0;
      assign mag_src  = d2_mag;
      assign neg_src  = d2_neg;
    end else begin : g_next
      assign x_src    = sq_x[s-1];
      assign rem_src  = sq_rem[s-1];
      assign root_src = sq_root[s-1];
      assign mag_src  = sq_mag[s-1];
      assign neg_src  = sq_neg[s-1];
    end

    always_comb begin
      x_c    = x_src;
      rem_c  = rem_src;
      root_c = root_src;
      for (int j = 0; j < vtp_pkg::SQRT_PER_STAGE; j++) begin
        if (s * vtp_pkg::SQRT_PER_STAGE + j < vtp_pkg::SQRT_BITS) begin
          rem_c = {rem_c[31:0], x_c[61:60]};
          x_c   = {x_c[59:0], 2'b00};
          if (rem_c >= {1'b0, root_c, 2'b01}) begin
            rem_c  = rem_c - {1'b0, root_c, 2'b01};
            root_c = {root_c[29:0], 1'b1};
          end else begin
            root_c = {root_c[29:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_x[s]    <= x_c;
        sq_rem[s]  <= rem_c;
        sq_root[s] <= root_c;
        sq_mag[s]  <= mag_src;
        sq_neg[s]  <= neg_src;
      end
    end
  end

  // Restoring division of 511 * |c| by the length, one quotient bit per step.
  logic [39:0] dv_rem [DS][3];
  logic [8:0]  dv_q [DS][3];
  logic [30:0] dv_len [DS];
  logic        dv_neg [DS][3];

  for (genvar t = 0; t < DS; t++) begin : g_div
    logic [39:0] rem_src [3];
    logic [8:0]  q_src [3];
    logic [30:0] len_src;
    logic        neg_src [3];
    logic [39:0] rem_c [3];
    logic [8:0]  q_c [3];
    logic [39:0] dsh;

    if (t == 0) begin : g_first
      assign len_src = sq_root[SS-1];
      assign neg_src = sq_neg[SS-1];
      for (genvar i = 0; i < 3; i++) begin : g_init
        assign rem_src[i] = 40'({sq_mag[SS-1][i], 9'b0}) - 40'(sq_mag[SS-1][i]);
        assign q_src[i]   = '0;
      end
    end else begin : g_next
      assign len_src = dv_len[t-1];
      assign neg_src = dv_neg[t-1];
      assign rem_src = dv_rem[t-1];
      assign q_src   = dv_q[t-1];
    end

    always_comb begin
      dsh   = '0;
      rem_c = rem_src;
      q_c   = q_src;
      for (int j = 0; j < vtp_pkg::DIV_PER_STAGE; j++) begin
        if (t * vtp_pkg::DIV_PER_STAGE + j < vtp_pkg::DIV_BITS) begin
          dsh = {9'b0, len_src} << (vtp_pkg::DIV_BITS - 1 - (t * vtp_pkg::DIV_PER_STAGE + j));
          for (int i = 0; i < 3; i++) begin
            if (rem_c[i] >= dsh) begin
              rem_c[i] = rem_c[i] - dsh;
              q_c[i]   = {q_c[i][7:0], 1'b1};
            end else begin
              q_c[i]   = {q_c[i][7:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[t] <= rem_c;
        dv_q[t]   <= q_c;
        dv_len[t] <= len_src;
        dv_neg[t] <= neg_src;
      end
    end
  end

  logic [9:0] fld [3];
  logic [9:0] mq [3];

  // Negative components round away from zero, so the quotient takes a ceiling.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mq[i] = 10'(dv_q[DS-1][i]) + 10'(dv_neg[DS-1][i] && (dv_rem[DS-1][i] != '0));
      if (dv_len[DS-1] == '0) begin
        fld[i] = vtp_pkg::FIELD_MID;
      end else if (dv_neg[DS-1][i]) begin
        fld[i] = vtp_pkg::FIELD_MID - mq[i];
      end else begin
        fld[i] = vtp_pkg::FIELD_MID + 10'(dv_q[DS-1][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fields <= {fld[2], fld[1], fld[0]};
    end
  end

endmodule

// ===== rtl/core/vertex_transform_pack.sv =====
// Channel   Handshake               Beat
// in        in_valid / in_ready     pos, norm, tan, tan_positive, tex
// out       out_valid / out_ready   out_x/y/z, packed_normal/tangent/uv, tint_out
// cfg       cfg_we                  cfg_index, cfg_data
//
// One vertex per cycle while the output is not stalled.
// Two product and sum stages feed vtp_dir_pack, which adds a square stage, a sum
// stage, eight square root stages of up to four steps, three quotient stages and a
// pack stage; the position path is delayed to match.
// Reset clears the valid bits and loads the identity matrix, full mode and white tint.
// A stalled output beat freezes the whole pipeline; in_ready is low only then.
module vertex_transform_pack (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [15:0] norm_x,
  input  logic signed [15:0] norm_y,
  input  logic signed [15:0] norm_z,
  input  logic signed [15:0] tan_x,
  input  logic signed [15:0] tan_y,
  input  logic signed [15:0] tan_z,
  input  logic               tan_positive,
  input  logic signed [31:0] tex_u,
  input  logic signed [31:0] tex_v,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [31:0]        packed_normal,
  output logic [31:0]        packed_tangent,
  output logic [31:0]        packed_uv,
  output logic [31:0]        tint_out,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] uv;
    logic        tan_pos;
  } pos_beat_t;

  logic [47:0] col_x, col_y, col_z;
  logic [63:0] trans_xy;
  logic [31:0] trans_z;
  logic [31:0] tint;
  logic [63:0] uv_xf;
  logic [1:0]  mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_x    <= 48'h0000_0000_1000;
      col_y    <= 48'h0000_1000_0000;
      col_z    <= 48'h1000_0000_0000;
      trans_xy <= '0;
      trans_z  <= '0;
      tint     <= 32'hFFFF_FFFF;
      uv_xf    <= 64'h0000_0000_0100_0100;
      mode     <= vtp_pkg::MODE_FULL;
    end else if (cfg_we) begin
      case (vtp_pkg::reg_idx_t'(cfg_index))
        vtp_pkg::REG_COL_X:    col_x    <= cfg_data[47:0];
        vtp_pkg::REG_COL_Y:    col_y    <= cfg_data[47:0];
        vtp_pkg::REG_COL_Z:    col_z    <= cfg_data[47:0];
        vtp_pkg::REG_TRANS_XY: trans_xy <= cfg_data;
        vtp_pkg::REG_TRANS_Z:  trans_z  <= cfg_data[31:0];
        vtp_pkg::REG_TINT:     tint     <= cfg_data[31:0];
        vtp_pkg::REG_UV:       uv_xf    <= cfg_data;
        vtp_pkg::REG_MODE:     mode     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic                               en;
  logic [vtp_pkg::PIPE_DEPTH-1:0]     v;

  assign en        = !v[vtp_pkg::PIPE_DEPTH-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = v[vtp_pkg::PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[vtp_pkg::PIPE_DEPTH-2:0], in_valid};
    end
  end

  logic [47:0]        col [3];
  logic signed [31:0] tr [3];
  logic signed [31:0] pin [3];
  logic signed [15:0] nin [3];
  logic signed [15:0] tin [3];

  assign col = '{col_x, col_y, col_z};
  assign tr  = '{trans_xy[31:0], trans_xy[63:32], trans_z};
  assign pin = '{pos_x, pos_y, pos_z};
  assign nin = '{norm_x, norm_y, norm_z};
  assign tin = '{tan_x, tan_y, tan_z};

  // Stage 1: one multiplier per matrix term for each of position, normal and tangent, plus the UV scales.
  logic signed [47:0] t1_pp [3][3];
  logic signed [31:0] t1_np [3][3];
  logic signed [31:0] t1_tp [3][3];
  logic signed [47:0] t1_uu, t1_uv;
  logic               t1_tan;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          t1_pp[r][i] <= 48'($signed(col[i][16*r +: 16])) * 48'(pin[i]);
          t1_np[r][i] <= 32'($signed(col[i][16*r +: 16])) * 32'(nin[i]);
          t1_tp[r][i] <= 32'($signed(col[i][16*r +: 16])) * 32'(tin[i]);
        end
      end
      t1_uu  <= 48'(tex_u) * 48'($signed(uv_xf[15:0]));
      t1_uv  <= 48'(tex_v) * 48'($signed(uv_xf[31:16]));
      t1_tan <= tan_positive;
    end
  end

  // Stage 2: sums, translation and UV clamp.
  logic signed [49:0]  t2_s [3];
  vtp_pkg::dir_comp_t  t2_rn [3];
  vtp_pkg::dir_comp_t  t2_rt [3];
  logic [24:0]         t2_u, t2_v;
  logic                t2_tan;
  logic signed [48:0]  uvs_u, uvs_v;
  logic [24:0]         uvc_u, uvc_v;

  always_comb begin
    uvs_u = 49'(t1_uu) + (49'($signed(uv_xf[47:32])) <<< 16);
    uvs_v = 49'(t1_uv) + (49'($signed(uv_xf[63:48])) <<< 16);
    if (uvs_u < 0) begin
      uvc_u = '0;
    end else if (uvs_u > 49'sd16777216) begin
      uvc_u = 25'd16777216;
    end else begin
      uvc_u = uvs_u[24:0];
    end
    if (uvs_v < 0) begin
      uvc_v = '0;
    end else if (uvs_v > 49'sd16777216) begin
      uvc_v = 25'd16777216;
    end else begin
      uvc_v = uvs_v[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        t2_s[r]  <= 50'(t1_pp[r][0]) + 50'(t1_pp[r][1]) + 50'(t1_pp[r][2])
                  + (50'(tr[r]) <<< 12);
        t2_rn[r] <= 33'(t1_np[r][0]) + 33'(t1_np[r][1]) + 33'(t1_np[r][2]);
        t2_rt[r] <= 33'(t1_tp[r][0]) + 33'(t1_tp[r][1]) + 33'(t1_tp[r][2]);
      end
      t2_u   <= uvc_u;
      t2_v   <= uvc_v;
      t2_tan <= t1_tan;
    end
  end

  // Stage 3: round positions to the nearest thousandth, ties away from zero, and scale UV to 16 bits.
  logic [47:0] sabs [3];
  logic [59:0] kscaled [3];
  logic [40:0] uvw_u, uvw_v;
  logic [31:0] t3_k [3];
  logic        t3_neg [3];
  logic [31:0] t3_uv;
  logic        t3_tan;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sabs[r]    = t2_s[r][49] ? 48'(-t2_s[r]) : 48'(t2_s[r]);
      kscaled[r] = (60'(sabs[r]) << 10) - (60'(sabs[r]) << 4) - (60'(sabs[r]) << 3)
                 + (60'd1 << 27);
    end
    uvw_u = {t2_u, 16'b0} - 41'(t2_u);
    uvw_v = {t2_v, 16'b0} - 41'(t2_v);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        t3_k[r]   <= kscaled[r][59:28];
        t3_neg[r] <= t2_s[r][49];
      end
      t3_uv  <= {uvw_v[39:24], uvw_u[39:24]};
      t3_tan <= t2_tan;
    end
  end

  // Stage 4: multiply by the reciprocal in two partial products.
  logic [43:0] t4_ph [3];
  logic [44:0] t4_pl [3];
  logic        t4_big [3];
  logic        t4_neg [3];
  logic [31:0] t4_uv;
  logic        t4_tan;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        t4_ph[r]  <= 44'(t3_k[r][24:0]) * 44'(vtp_pkg::RECIP_HI);
        t4_pl[r]  <= 45'(t3_k[r][24:0]) * 45'(vtp_pkg::RECIP_LO);
        t4_big[r] <= t3_k[r][31:25] != '0;
        t4_neg[r] <= t3_neg[r];
      end
      t4_uv  <= t3_uv;
      t4_tan <= t3_tan;
    end
  end

  // Rescale to Q16.16 and saturate; a magnitude of 2^25 thousandths always saturates.
  logic [63:0] rprod [3];
  logic [31:0] rq [3];
  logic [31:0] pos_o [3];
  pos_beat_t   dly [vtp_pkg::POS_DLY];
  pos_beat_t   dly_in;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rprod[r] = (64'(t4_ph[r]) << 20) + 64'(t4_pl[r]);
      rq[r]    = rprod[r][63:32];
      if (!t4_neg[r]) begin
        pos_o[r] = (t4_big[r] || rq[r][31]) ? 32'h7FFF_FFFF : rq[r];
      end else begin
        pos_o[r] = (t4_big[r] || rq[r] > 32'h8000_0000) ? 32'h8000_0000 : 32'(-rq[r]);
      end
    end
    dly_in = '{x: pos_o[0], y: pos_o[1], z: pos_o[2], uv: t4_uv, tan_pos: t4_tan};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly[0] <= dly_in;
      for (int k = 1; k < vtp_pkg::POS_DLY; k++) begin
        dly[k] <= dly[k-1];
      end
    end
  end

  logic [29:0] nrm_fields, tng_fields;

  vtp_dir_pack u_norm (
    .clk    (clk),
    .en     (en),
    .comp   (t2_rn),
    .fields (nrm_fields)
  );

  vtp_dir_pack u_tang (
    .clk    (clk),
    .en     (en),
    .comp   (t2_rt),
    .fields (tng_fields)
  );

  pos_beat_t last;
  logic      shadow, gi;

  assign last   = dly[vtp_pkg::POS_DLY-1];
  assign shadow = mode == vtp_pkg::MODE_SHADOW;
  assign gi     = mode == vtp_pkg::MODE_GI;

  assign out_x          = last.x;
  assign out_y          = last.y;
  assign out_z          = last.z;
  assign packed_normal  = shadow ? '0 : {2'b00, nrm_fields};
  assign packed_tangent = (shadow || gi) ? '0 : {{2{last.tan_pos}}, tng_fields};
  assign packed_uv      = shadow ? '0 : last.uv;
  assign tint_out       = shadow ? '0 : tint;

`ifndef SYNTHESIS
  a_shadow_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && shadow |-> packed_normal == '0 && packed_uv == '0 && tint_out == '0)
    else $error("shadow beat carries attribute data");

  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !shadow |->
      packed_normal[9:0] <= 10'd1022 && packed_normal[19:10] <= 10'd1022
      && packed_normal[29:20] <= 10'd1022)
    else $error("normal field outside the unorm range");

  a_tangent_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> packed_tangent[31] == packed_tangent[30])
    else $error("tangent sign bits disagree");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v[0])
    else $error("accepted beat did not enter the pipeline");
`endif

endmodule
